>>> design/rvid_pkg.sv
`default_nettype none

package rvid_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned RegWidth  = 5;
   localparam int unsigned ImmWidth  = 21;
   localparam int unsigned RspWidth  = 48;

   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_OPIMM  = 7'h13;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_JAL    = 7'h6F;

   typedef enum logic [3:0] {
      CLS_BAD    = 4'd0,
      CLS_OP     = 4'd1,
      CLS_OPIMM  = 4'd2,
      CLS_LOAD   = 4'd3,
      CLS_JALR   = 4'd4,
      CLS_SYSTEM = 4'd5,
      CLS_STORE  = 4'd6,
      CLS_BRANCH = 4'd7,
      CLS_LUI    = 4'd8,
      CLS_AUIPC  = 4'd9,
      CLS_JAL    = 4'd10
   } opclass_type;

   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_OPCODE = 2'd1,
      ERR_FUNCT3 = 2'd2
   } error_type;

   typedef enum logic [2:0] {
      FMT_R = 3'd0,
      FMT_I = 3'd1,
      FMT_S = 3'd2,
      FMT_B = 3'd3,
      FMT_U = 3'd4,
      FMT_J = 3'd5
   } format_type;

   typedef enum logic [5:0] {
      MN_NONE   = 6'd0,
      MN_LUI    = 6'd1,
      MN_AUIPC  = 6'd2,
      MN_JAL    = 6'd3,
      MN_JALR   = 6'd4,
      MN_BEQ    = 6'd5,
      MN_BNE    = 6'd6,
      MN_BLT    = 6'd7,
      MN_BGE    = 6'd8,
      MN_BLTU   = 6'd9,
      MN_BGEU   = 6'd10,
      MN_LB     = 6'd11,
      MN_LH     = 6'd12,
      MN_LW     = 6'd13,
      MN_LBU    = 6'd14,
      MN_LHU    = 6'd15,
      MN_SB     = 6'd16,
      MN_SH     = 6'd17,
      MN_SW     = 6'd18,
      MN_ADDI   = 6'd19,
      MN_SLTI   = 6'd20,
      MN_SLTIU  = 6'd21,
      MN_XORI   = 6'd22,
      MN_ORI    = 6'd23,
      MN_ANDI   = 6'd24,
      MN_SLLI   = 6'd25,
      MN_SRLI   = 6'd26,
      MN_SRAI   = 6'd27,
      MN_ADD    = 6'd28,
      MN_SUB    = 6'd29,
      MN_SLL    = 6'd30,
      MN_SLT    = 6'd31,
      MN_SLTU   = 6'd32,
      MN_XOR    = 6'd33,
      MN_SRL    = 6'd34,
      MN_SRA    = 6'd35,
      MN_OR     = 6'd36,
      MN_AND    = 6'd37,
      MN_ECALL  = 6'd38,
      MN_EBREAK = 6'd39
   } mnemonic_type;

   typedef struct packed {
      opclass_type               cls;
      logic [2:0]                f3;
      logic                      b30;
      logic                      sys_imm_nz;
      logic [RegWidth-1:0]       rd;
      logic [RegWidth-1:0]       rs1;
      logic [RegWidth-1:0]       rs2;
      logic signed [ImmWidth-1:0] imm;
   } decode_type;

endpackage

`default_nettype wire

>>> design/rvid_field_decode.sv
`default_nettype none

module rvid_field_decode (
   input  wire logic [rvid_pkg::WordWidth-1:0] word,
   output rvid_pkg::decode_type                 dec
);

   logic signed [rvid_pkg::ImmWidth-1:0] imm_i;
   logic signed [rvid_pkg::ImmWidth-1:0] imm_s;
   logic signed [rvid_pkg::ImmWidth-1:0] imm_b;
   logic signed [rvid_pkg::ImmWidth-1:0] imm_u;
   logic signed [rvid_pkg::ImmWidth-1:0] imm_j;
   logic signed [rvid_pkg::ImmWidth-1:0] imm_sh;
   rvid_pkg::opclass_type                cls;

   assign imm_i  = {{9{word[31]}}, word[31:20]};
   assign imm_s  = {{9{word[31]}}, word[31:25], word[11:7]};
   assign imm_b  = {{8{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
   assign imm_u  = {1'b0, word[31:12]};
   assign imm_j  = {word[31], word[19:12], word[20], word[30:21], 1'b0};
   assign imm_sh = {16'd0, word[24:20]};

   always_comb begin
      unique case (word[6:0])
         rvid_pkg::OPC_OP:     cls = rvid_pkg::CLS_OP;
         rvid_pkg::OPC_OPIMM:  cls = rvid_pkg::CLS_OPIMM;
         rvid_pkg::OPC_LOAD:   cls = rvid_pkg::CLS_LOAD;
         rvid_pkg::OPC_JALR:   cls = rvid_pkg::CLS_JALR;
         rvid_pkg::OPC_SYSTEM: cls = rvid_pkg::CLS_SYSTEM;
         rvid_pkg::OPC_STORE:  cls = rvid_pkg::CLS_STORE;
         rvid_pkg::OPC_BRANCH: cls = rvid_pkg::CLS_BRANCH;
         rvid_pkg::OPC_LUI:    cls = rvid_pkg::CLS_LUI;
         rvid_pkg::OPC_AUIPC:  cls = rvid_pkg::CLS_AUIPC;
         rvid_pkg::OPC_JAL:    cls = rvid_pkg::CLS_JAL;
         default:              cls = rvid_pkg::CLS_BAD;
      endcase
   end

   always_comb begin
      dec.cls        = cls;
      dec.f3         = word[14:12];
      dec.b30        = word[30];
      dec.sys_imm_nz = |word[31:20];
      dec.rd         = word[11:7];
      dec.rs1        = word[19:15];
      dec.rs2        = word[24:20];
      unique case (cls)
         rvid_pkg::CLS_OPIMM: begin
            if (word[13:12] == 2'b01) begin
               dec.imm = imm_sh;
            end else begin
               dec.imm = imm_i;
            end
         end
         rvid_pkg::CLS_LOAD,
         rvid_pkg::CLS_JALR,
         rvid_pkg::CLS_SYSTEM: dec.imm = imm_i;
         rvid_pkg::CLS_STORE:  dec.imm = imm_s;
         rvid_pkg::CLS_BRANCH: dec.imm = imm_b;
         rvid_pkg::CLS_LUI,
         rvid_pkg::CLS_AUIPC:  dec.imm = imm_u;
         rvid_pkg::CLS_JAL:    dec.imm = imm_j;
         default:              dec.imm = '0;
      endcase
   end

endmodule

`default_nettype wire

>>> design/rv32i_instruction_decoder.sv
// RV32I instruction decoder.
// Input stream: req_tdata carries one 32-bit instruction word per transaction.
// Output stream: rsp_tdata carries one decoded result per transaction:
//   error code, format, mnemonic code, rd, rs1, rs2 and the 21-bit immediate.
//   Unknown opcodes and illegal funct3 values come back flagged in the error
//   code with mnemonic, registers and immediate cleared; funct3 errors keep the format.
// Pipeline: three register stages (word capture, field/immediate extraction,
//   mnemonic lookup and masking), each registered in turn before rsp_tvalid
//   rises; throughput is one transaction per cycle while rsp_tready is high.
// Each stage carries its own valid bit and moves when the stage after it is
//   empty or moving, so bubbles are squeezed out. When rsp_tready is low the
//   full stages hold their contents; up to three words are held in flight and
//   nothing is dropped or duplicated.
// Reset clears all valid bits, so the block is ready to accept a word as soon
//   as reset is released.
`default_nettype none

module rv32i_instruction_decoder (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output      logic                          req_tready,
   input  wire logic [rvid_pkg::WordWidth-1:0] req_tdata, // [31:0] instr_word
   output      logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [1:0] error_code, [4:2] format_code, [10:5] mnemonic_code,
   // [15:11] dest_reg, [20:16] src1_reg, [25:21] src2_reg,
   // [46:26] imm_value, [47] zero
   output      logic [rvid_pkg::RspWidth-1:0] rsp_tdata
);

   logic                           s1_valid_ff, s1_valid_in;
   logic                           s2_valid_ff, s2_valid_in;
   logic                           s3_valid_ff, s3_valid_in;
   logic [rvid_pkg::WordWidth-1:0] s1_word_ff, s1_word_in;
   rvid_pkg::decode_type           s2_dec_ff, s2_dec_in;
   logic [rvid_pkg::RspWidth-1:0]  s3_data_ff, s3_data_in;

   logic adv1, adv2, adv3;

   rvid_pkg::decode_type    dec_now;
   rvid_pkg::error_type     err;
   rvid_pkg::format_type    fmt;
   rvid_pkg::mnemonic_type  mn;
   logic                    use_rd, use_rs1, use_rs2;
   logic [rvid_pkg::RegWidth-1:0]        rd_o, rs1_o, rs2_o;
   logic signed [rvid_pkg::ImmWidth-1:0] imm_o;
   rvid_pkg::mnemonic_type  mn_o;

   assign adv3 = !s3_valid_ff || rsp_tready;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;

   assign req_tready = adv1;
   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tdata  = s3_data_ff;

   rvid_field_decode u_field_decode (
      .word (s1_word_ff),
      .dec  (dec_now)
   );

   // stage 3: mnemonic lookup, error check, field masking
   always_comb begin
      err     = rvid_pkg::ERR_NONE;
      fmt     = rvid_pkg::FMT_R;
      mn      = rvid_pkg::MN_NONE;
      use_rd  = 1'b1;
      use_rs1 = 1'b1;
      use_rs2 = 1'b0;
      unique case (s2_dec_ff.cls)
         rvid_pkg::CLS_OP: begin
            fmt     = rvid_pkg::FMT_R;
            use_rs2 = 1'b1;
            unique case (s2_dec_ff.f3)
               3'd0: mn = s2_dec_ff.b30 ? rvid_pkg::MN_SUB : rvid_pkg::MN_ADD;
               3'd1: mn = rvid_pkg::MN_SLL;
               3'd2: mn = rvid_pkg::MN_SLT;
               3'd3: mn = rvid_pkg::MN_SLTU;
               3'd4: mn = rvid_pkg::MN_XOR;
               3'd5: mn = s2_dec_ff.b30 ? rvid_pkg::MN_SRA : rvid_pkg::MN_SRL;
               3'd6: mn = rvid_pkg::MN_OR;
               default: mn = rvid_pkg::MN_AND;
            endcase
         end
         rvid_pkg::CLS_OPIMM: begin
            fmt = rvid_pkg::FMT_I;
            unique case (s2_dec_ff.f3)
               3'd0: mn = rvid_pkg::MN_ADDI;
               3'd1: mn = rvid_pkg::MN_SLLI;
               3'd2: mn = rvid_pkg::MN_SLTI;
               3'd3: mn = rvid_pkg::MN_SLTIU;
               3'd4: mn = rvid_pkg::MN_XORI;
               3'd5: mn = s2_dec_ff.b30 ? rvid_pkg::MN_SRAI : rvid_pkg::MN_SRLI;
               3'd6: mn = rvid_pkg::MN_ORI;
               default: mn = rvid_pkg::MN_ANDI;
            endcase
         end
         rvid_pkg::CLS_LOAD: begin
            fmt = rvid_pkg::FMT_I;
            unique case (s2_dec_ff.f3)
               3'd0: mn = rvid_pkg::MN_LB;
               3'd1: mn = rvid_pkg::MN_LH;
               3'd2: mn = rvid_pkg::MN_LW;
               3'd4: mn = rvid_pkg::MN_LBU;
               3'd5: mn = rvid_pkg::MN_LHU;
               default: err = rvid_pkg::ERR_FUNCT3;
            endcase
         end
         rvid_pkg::CLS_JALR: begin
            fmt = rvid_pkg::FMT_I;
            mn  = rvid_pkg::MN_JALR;
            if (s2_dec_ff.f3 != 3'd0) begin
               err = rvid_pkg::ERR_FUNCT3;
            end
         end
         rvid_pkg::CLS_SYSTEM: begin
            fmt = rvid_pkg::FMT_I;
            mn  = s2_dec_ff.sys_imm_nz ? rvid_pkg::MN_EBREAK : rvid_pkg::MN_ECALL;
            if (s2_dec_ff.f3 != 3'd0) begin
               err = rvid_pkg::ERR_FUNCT3;
            end
         end
         rvid_pkg::CLS_STORE: begin
            fmt     = rvid_pkg::FMT_S;
            use_rd  = 1'b0;
            use_rs2 = 1'b1;
            unique case (s2_dec_ff.f3)
               3'd0: mn = rvid_pkg::MN_SB;
               3'd1: mn = rvid_pkg::MN_SH;
               3'd2: mn = rvid_pkg::MN_SW;
               default: err = rvid_pkg::ERR_FUNCT3;
            endcase
         end
         rvid_pkg::CLS_BRANCH: begin
            fmt     = rvid_pkg::FMT_B;
            use_rd  = 1'b0;
            use_rs2 = 1'b1;
            unique case (s2_dec_ff.f3)
               3'd0: mn = rvid_pkg::MN_BEQ;
               3'd1: mn = rvid_pkg::MN_BNE;
               3'd4: mn = rvid_pkg::MN_BLT;
               3'd5: mn = rvid_pkg::MN_BGE;
               3'd6: mn = rvid_pkg::MN_BLTU;
               3'd7: mn = rvid_pkg::MN_BGEU;
               default: err = rvid_pkg::ERR_FUNCT3;
            endcase
         end
         rvid_pkg::CLS_LUI: begin
            fmt     = rvid_pkg::FMT_U;
            mn      = rvid_pkg::MN_LUI;
            use_rs1 = 1'b0;
         end
         rvid_pkg::CLS_AUIPC: begin
            fmt     = rvid_pkg::FMT_U;
            mn      = rvid_pkg::MN_AUIPC;
            use_rs1 = 1'b0;
         end
         rvid_pkg::CLS_JAL: begin
            fmt     = rvid_pkg::FMT_J;
            mn      = rvid_pkg::MN_JAL;
            use_rs1 = 1'b0;
         end
         default: begin
            err = rvid_pkg::ERR_OPCODE;
         end
      endcase

      if (err != rvid_pkg::ERR_NONE) begin
         mn_o  = rvid_pkg::MN_NONE;
         rd_o  = '0;
         rs1_o = '0;
         rs2_o = '0;
         imm_o = '0;
      end else begin
         mn_o  = mn;
         rd_o  = use_rd  ? s2_dec_ff.rd  : '0;
         rs1_o = use_rs1 ? s2_dec_ff.rs1 : '0;
         rs2_o = use_rs2 ? s2_dec_ff.rs2 : '0;
         imm_o = s2_dec_ff.imm;
      end
   end

   always_comb begin
      s1_valid_in = adv1 ? req_tvalid  : s1_valid_ff;
      s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;
      s3_valid_in = adv3 ? s2_valid_ff : s3_valid_ff;
      s1_word_in  = (adv1 && req_tvalid)  ? req_tdata : s1_word_ff;
      s2_dec_in   = (adv2 && s1_valid_ff) ? dec_now   : s2_dec_ff;
      s3_data_in  = (adv3 && s2_valid_ff) ?
                    {1'b0, imm_o, rs2_o, rs1_o, rd_o, mn_o, fmt, err} : s3_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_word_ff <= s1_word_in;
      s2_dec_ff  <= s2_dec_in;
      s3_data_ff <= s3_data_in;
   end

endmodule

`default_nettype wire

>>> tb/rv32i_instruction_decoder_test.sv
`timescale 1ns / 100ps

module rv32i_instruction_decoder_test;

   localparam int StallLimit = 2000;
   localparam int HoldCycles = 90;
   localparam int TailCycles = 8;

   typedef struct packed {
      rvid_pkg::error_type    err;
      rvid_pkg::format_type   fmt;
      rvid_pkg::mnemonic_type mn;
      logic [4:0]   rd;
      logic [4:0]   rs1;
      logic [4:0]   rs2;
      logic [20:0]  imm;
   } decoded_type;

   typedef struct packed {
      logic [31:0] word;
      decoded_type fields;
   } pending_decode_type;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [rvid_pkg::WordWidth-1:0] req_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [rvid_pkg::RspWidth-1:0]  rsp_tdata;

   pending_decode_type pending_decodes[$];
   int              mismatch_count = 0;
   int              stall_cycles = 0;
   int              hold_left = 0;
   bit              hold_request = 1'b0;
   bit              send_idle_on = 1'b1;
   bit              recv_idle_on = 1'b1;

   rv32i_instruction_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic decoded_type decode_instruction(input logic [31:0] w);
      decoded_type d;
      logic [6:0] opc;
      logic [2:0] f3;
      logic [20:0] imm_i;
      d = '0;
      d.err = rvid_pkg::ERR_NONE;
      d.fmt = rvid_pkg::FMT_R;
      d.mn = rvid_pkg::MN_NONE;
      opc = w[6:0];
      f3 = w[14:12];
      imm_i = {{9{w[31]}}, w[31:20]};
      case (opc)
         rvid_pkg::OPC_OP: begin
            d.fmt = rvid_pkg::FMT_R;
            d.rd = w[11:7];
            d.rs1 = w[19:15];
            d.rs2 = w[24:20];
            case (f3)
               3'd0: d.mn = w[30] ? rvid_pkg::MN_SUB : rvid_pkg::MN_ADD;
               3'd1: d.mn = rvid_pkg::MN_SLL;
               3'd2: d.mn = rvid_pkg::MN_SLT;
               3'd3: d.mn = rvid_pkg::MN_SLTU;
               3'd4: d.mn = rvid_pkg::MN_XOR;
               3'd5: d.mn = w[30] ? rvid_pkg::MN_SRA : rvid_pkg::MN_SRL;
               3'd6: d.mn = rvid_pkg::MN_OR;
               default: d.mn = rvid_pkg::MN_AND;
            endcase
         end
         rvid_pkg::OPC_OPIMM: begin
            d.fmt = rvid_pkg::FMT_I;
            d.rd = w[11:7];
            d.rs1 = w[19:15];
            d.imm = imm_i;
            case (f3)
               3'd0: d.mn = rvid_pkg::MN_ADDI;
               3'd1: begin
                  d.mn = rvid_pkg::MN_SLLI;
                  d.imm = {16'd0, w[24:20]};
               end
               3'd2: d.mn = rvid_pkg::MN_SLTI;
               3'd3: d.mn = rvid_pkg::MN_SLTIU;
               3'd4: d.mn = rvid_pkg::MN_XORI;
               3'd5: begin
                  d.mn = w[30] ? rvid_pkg::MN_SRAI : rvid_pkg::MN_SRLI;
                  d.imm = {16'd0, w[24:20]};
               end
               3'd6: d.mn = rvid_pkg::MN_ORI;
               default: d.mn = rvid_pkg::MN_ANDI;
            endcase
         end
         rvid_pkg::OPC_LOAD: begin
            d.fmt = rvid_pkg::FMT_I;
            d.rd = w[11:7];
            d.rs1 = w[19:15];
            d.imm = imm_i;
            case (f3)
               3'd0: d.mn = rvid_pkg::MN_LB;
               3'd1: d.mn = rvid_pkg::MN_LH;
               3'd2: d.mn = rvid_pkg::MN_LW;
               3'd4: d.mn = rvid_pkg::MN_LBU;
               3'd5: d.mn = rvid_pkg::MN_LHU;
               default: d.err = rvid_pkg::ERR_FUNCT3;
            endcase
         end
         rvid_pkg::OPC_JALR: begin
            d.fmt = rvid_pkg::FMT_I;
            d.rd = w[11:7];
            d.rs1 = w[19:15];
            d.imm = imm_i;
            d.mn = rvid_pkg::MN_JALR;
            if (f3 != 3'd0) d.err = rvid_pkg::ERR_FUNCT3;
         end
         rvid_pkg::OPC_SYSTEM: begin
            d.fmt = rvid_pkg::FMT_I;
            d.rd = w[11:7];
            d.rs1 = w[19:15];
            d.imm = imm_i;
            d.mn = (w[31:20] != 12'd0) ? rvid_pkg::MN_EBREAK : rvid_pkg::MN_ECALL;
            if (f3 != 3'd0) d.err = rvid_pkg::ERR_FUNCT3;
         end
         rvid_pkg::OPC_STORE: begin
            d.fmt = rvid_pkg::FMT_S;
            d.rs1 = w[19:15];
            d.rs2 = w[24:20];
            d.imm = {{9{w[31]}}, w[31:25], w[11:7]};
            case (f3)
               3'd0: d.mn = rvid_pkg::MN_SB;
               3'd1: d.mn = rvid_pkg::MN_SH;
               3'd2: d.mn = rvid_pkg::MN_SW;
               default: d.err = rvid_pkg::ERR_FUNCT3;
            endcase
         end
         rvid_pkg::OPC_BRANCH: begin
            d.fmt = rvid_pkg::FMT_B;
            d.rs1 = w[19:15];
            d.rs2 = w[24:20];
            d.imm = {{8{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            case (f3)
               3'd0: d.mn = rvid_pkg::MN_BEQ;
               3'd1: d.mn = rvid_pkg::MN_BNE;
               3'd4: d.mn = rvid_pkg::MN_BLT;
               3'd5: d.mn = rvid_pkg::MN_BGE;
               3'd6: d.mn = rvid_pkg::MN_BLTU;
               3'd7: d.mn = rvid_pkg::MN_BGEU;
               default: d.err = rvid_pkg::ERR_FUNCT3;
            endcase
         end
         rvid_pkg::OPC_LUI, rvid_pkg::OPC_AUIPC: begin
            d.fmt = rvid_pkg::FMT_U;
            d.rd = w[11:7];
            d.imm = {1'b0, w[31:12]};
            d.mn = (opc == rvid_pkg::OPC_LUI) ? rvid_pkg::MN_LUI : rvid_pkg::MN_AUIPC;
         end
         rvid_pkg::OPC_JAL: begin
            d.fmt = rvid_pkg::FMT_J;
            d.rd = w[11:7];
            d.mn = rvid_pkg::MN_JAL;
            d.imm = {w[31], w[19:12], w[20], w[30:21], 1'b0};
         end
         default: d.err = rvid_pkg::ERR_OPCODE;
      endcase
      if (d.err != rvid_pkg::ERR_NONE) begin
         if (d.err == rvid_pkg::ERR_OPCODE) d.fmt = rvid_pkg::FMT_R;
         d.mn = rvid_pkg::MN_NONE;
         d.rd = '0;
         d.rs1 = '0;
         d.rs2 = '0;
         d.imm = '0;
      end
      return d;
   endfunction

   function automatic logic [6:0] opcode_by_index(input int i);
      case (i)
         0: return rvid_pkg::OPC_OP;
         1: return rvid_pkg::OPC_OPIMM;
         2: return rvid_pkg::OPC_LOAD;
         3: return rvid_pkg::OPC_JALR;
         4: return rvid_pkg::OPC_SYSTEM;
         5: return rvid_pkg::OPC_STORE;
         6: return rvid_pkg::OPC_BRANCH;
         7: return rvid_pkg::OPC_LUI;
         8: return rvid_pkg::OPC_AUIPC;
         default: return rvid_pkg::OPC_JAL;
      endcase
   endfunction

   // mostly known opcodes with random fields, some noise words and FENCE
   function automatic logic [31:0] random_instruction();
      logic [31:0] w;
      int          pick;
      w = $urandom();
      pick = $urandom_range(99);
      if (pick < 85) begin
         w[6:0] = opcode_by_index($urandom_range(9));
         if (w[6:0] == rvid_pkg::OPC_SYSTEM && $urandom_range(3) == 0) begin
            w[31:20] = '0;
            w[14:12] = 3'd0;
         end
      end else if (pick < 89) begin
         w[6:0] = 7'h0F;
      end
      return w;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] word,
                                  input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: word %h got %0h expected %0h", what, word, got, want);
      mismatch_count++;
   endtask

   task automatic send_instruction(input logic [31:0] w);
      if (send_idle_on) begin
         while ($urandom_range(99) < 19) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata <= w;
      do @(posedge clock); while (req_tready !== 1'b1);
      pending_decodes.push_back({w, decode_instruction(w)});
   endtask

   task automatic test_special_words();
      logic [31:0] words[$];
      words = '{
         32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_000F, 32'hFFFF_F0B7, 32'h0000_0017,
         32'h8000_00EF, 32'hFFFF_FFEF, 32'hFFF0_8067, 32'h0000_1067, 32'h0000_0073,
         32'h0010_0073, 32'hFFF0_0073, 32'h0000_2073, 32'h0000_2063, 32'h0000_3063,
         32'h8000_0063, 32'h7FFF_FFE3, 32'h0000_3003, 32'h0000_6003, 32'h0000_7003,
         32'h0000_3023, 32'h8000_0023, 32'hFE00_0033, 32'hBE00_5033, 32'hFFF0_5013,
         32'hBFF0_1013, 32'h8000_0013, 32'h7FF0_0013
      };
      foreach (words[i]) send_instruction(words[i]);
   endtask

   task automatic test_operation_sweep();
      logic [31:0] w;
      for (int i = 0; i < 10; i++) begin
         for (int f3 = 0; f3 < 8; f3++) begin
            for (int b30 = 0; b30 < 2; b30++) begin
               w = $urandom();
               w[6:0] = opcode_by_index(i);
               w[14:12] = f3[2:0];
               w[30] = b30[0];
               send_instruction(w);
            end
         end
      end
   endtask

   task automatic test_random_traffic(input int count);
      repeat (count) send_instruction(random_instruction());
   endtask

   task automatic test_back_to_back(input int count);
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      test_random_traffic(count);
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
   endtask

   task automatic test_output_backpressure();
      hold_request <= 1'b1;
      test_random_traffic(40);
   endtask

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_special_words();
      test_operation_sweep();
      test_random_traffic(580);
      test_back_to_back(300);
      test_output_backpressure();
      test_random_traffic(350);
      req_tvalid <= 1'b0;
      while (pending_decodes.size() != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS rv32i_instruction_decoder");
      end else begin
         $display("FAIL rv32i_instruction_decoder");
      end
      $finish;
   end

   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left = HoldCycles;
            hold_request <= 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (recv_idle_on) begin
            rsp_tready <= ($urandom_range(99) >= 19);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      pending_decode_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (pending_decodes.size() == 0) begin
            report_mismatch("unexpected transaction", 32'd0, rsp_tdata[31:0], 32'd0);
         end else begin
            want = pending_decodes.pop_front();
            if (rsp_tdata[1:0] !== want.fields.err)
               report_mismatch("error_code", want.word, rsp_tdata[1:0], want.fields.err);
            if (rsp_tdata[4:2] !== want.fields.fmt)
               report_mismatch("format_code", want.word, rsp_tdata[4:2], want.fields.fmt);
            if (rsp_tdata[10:5] !== want.fields.mn)
               report_mismatch("mnemonic_code", want.word, rsp_tdata[10:5], want.fields.mn);
            if (rsp_tdata[15:11] !== want.fields.rd)
               report_mismatch("dest_reg", want.word, rsp_tdata[15:11], want.fields.rd);
            if (rsp_tdata[20:16] !== want.fields.rs1)
               report_mismatch("src1_reg", want.word, rsp_tdata[20:16], want.fields.rs1);
            if (rsp_tdata[25:21] !== want.fields.rs2)
               report_mismatch("src2_reg", want.word, rsp_tdata[25:21], want.fields.rs2);
            if (rsp_tdata[46:26] !== want.fields.imm)
               report_mismatch("imm_value", want.word, rsp_tdata[46:26], want.fields.imm);
            if (rsp_tdata[47] !== 1'b0)
               report_mismatch("pad bit", want.word, rsp_tdata[47], 32'd0);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid === 1'b1 && req_tready === 1'b1) ||
          (rsp_tvalid === 1'b1 && rsp_tready === 1'b1)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= StallLimit) begin
         $display("FAIL rv32i_instruction_decoder");
         $finish;
      end
   end

endmodule

>>> sim.f
design/rvid_pkg.sv
design/rvid_field_decode.sv
design/rv32i_instruction_decoder.sv
tb/rv32i_instruction_decoder_test.sv
